@@ hdl/rvx_pkg.sv @@
// shared types, codes and helper functions of the rv32im execute unit
package rvx_pkg;

    localparam int XLEN       = 32;
    localparam int DIV_STAGES = XLEN;
    localparam int IN_W       = 176;
    localparam int OUT_W      = 104;

    localparam logic [3:0] CLS_REG   = 4'd0;
    localparam logic [3:0] CLS_IMM   = 4'd1;
    localparam logic [3:0] CLS_LOAD  = 4'd2;
    localparam logic [3:0] CLS_STORE = 4'd3;
    localparam logic [3:0] CLS_BR    = 4'd4;
    localparam logic [3:0] CLS_LUI   = 4'd5;
    localparam logic [3:0] CLS_AUIPC = 4'd6;
    localparam logic [3:0] CLS_JAL   = 4'd7;
    localparam logic [3:0] CLS_JALR  = 4'd8;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    localparam logic [XLEN-1:0] LINK_OFS  = 32'd4;
    localparam logic [XLEN-1:0] WORD_MASK = 32'hFFFFFFFC;
    localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFFF000;
    localparam logic [XLEN-1:0] JALR_MASK = 32'hFFFFFFFE;

    // one in-flight instruction between stages
    typedef struct packed {
        logic [XLEN-1:0]   res_nd;
        logic              wr;
        logic              taken;
        logic [XLEN-1:0]   tgt;
        logic [XLEN-1:0]   addr;
        logic              ill;
        logic              is_mul;
        logic              mul_hi;
        logic [2*XLEN-1:0] prod;
        logic              is_div;
        logic              is_rem;
        logic              div0;
        logic              neg_q;
        logic              neg_r;
        logic [XLEN-1:0]   rem;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   dvs;
    } pipe_t;

    function automatic logic lt_s(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
        lt_s = $signed(a) < $signed(b);
    endfunction

    function automatic logic [XLEN-1:0] alu_op(input logic [2:0] f3, input logic alt,
                                               input logic [XLEN-1:0] a,
                                               input logic [XLEN-1:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            F3_ADD:  alu_op = alt ? a - b : a + b;
            F3_SLL:  alu_op = a << sh;
            F3_SLT:  alu_op = {{(XLEN-1){1'b0}}, lt_s(a, b)};
            F3_SLTU: alu_op = {{(XLEN-1){1'b0}}, (a < b)};
            F3_XOR:  alu_op = a ^ b;
            F3_SR:   alu_op = alt ? XLEN'($signed(a) >>> sh) : a >> sh;
            F3_OR:   alu_op = a | b;
            default: alu_op = a & b;
        endcase
    endfunction

endpackage

@@ hdl/rvx_front.sv @@
// first stage: decode, alu, branch, load extraction, multiply and divider setup
module rvx_front import rvx_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [3:0]      req_type,
    input  logic [2:0]      func3,
    input  logic [6:0]      func7,
    input  logic [XLEN-1:0] rs1_val,
    input  logic [XLEN-1:0] rs2_val,
    input  logic [XLEN-1:0] imm,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] load_word,
    output logic            out_valid,
    output pipe_t           out_pipe
);

    logic            valid_reg;
    pipe_t           pipe_reg;
    pipe_t           p;
    logic [XLEN-1:0] ea;
    logic [XLEN-1:0] shifted;
    logic            alt;
    logic            md;
    logic            sa;
    logic            sb;
    logic            sgn;
    logic            na;
    logic            nb;
    logic [2*XLEN+1:0] prod_full;

    always_comb begin
        ea        = rs1_val + imm;
        shifted   = load_word >> {ea[1:0], 3'b000};
        alt       = (func7 != 7'd0);
        md        = (req_type == CLS_REG) && func7[0];
        sa        = (func3 == F3_MULH || func3 == F3_MULHSU) && rs1_val[XLEN-1];
        sb        = (func3 == F3_MULH) && rs2_val[XLEN-1];
        prod_full = ($signed({sa, rs1_val}) * $signed({sb, rs2_val}));
        sgn       = !func3[0];
        na        = sgn && rs1_val[XLEN-1];
        nb        = sgn && rs2_val[XLEN-1];

        p         = '0;
        p.prod    = prod_full[2*XLEN-1:0];
        p.is_mul  = md && !func3[2];
        p.mul_hi  = (func3 != F3_MUL);
        p.is_div  = md && func3[2];
        p.is_rem  = func3[1];
        p.div0    = (rs2_val == '0);
        p.neg_q   = na ^ nb;
        p.neg_r   = na;
        p.quo     = na ? -rs1_val : rs1_val;
        p.dvs     = nb ? -rs2_val : rs2_val;

        unique case (req_type)
            CLS_REG: begin
                // dividend kept for the divide-by-zero remainder
                p.res_nd = md ? rs1_val : alu_op(func3, alt, rs1_val, rs2_val);
                p.wr     = 1'b1;
            end
            CLS_IMM: begin
                p.res_nd = alu_op(func3, (func3 == F3_SR) && alt, rs1_val, imm);
                p.wr     = 1'b1;
            end
            CLS_LOAD: begin
                p.addr = ea & WORD_MASK;
                p.wr   = 1'b1;
                case (func3)
                    F3_LB:   p.res_nd = {{24{shifted[7]}}, shifted[7:0]};
                    F3_LH:   p.res_nd = {{16{shifted[15]}}, shifted[15:0]};
                    F3_LW:   p.res_nd = load_word;
                    F3_LBU:  p.res_nd = {24'd0, shifted[7:0]};
                    F3_LHU:  p.res_nd = {16'd0, shifted[15:0]};
                    default: p.ill    = 1'b1;
                endcase
            end
            CLS_STORE: begin
                if (func3 <= 3'd2) begin
                    p.addr = ea;
                end else begin
                    p.ill = 1'b1;
                end
            end
            CLS_BR: begin
                p.tgt = pc + imm;
                case (func3)
                    F3_BEQ:  p.taken = (rs1_val == rs2_val);
                    F3_BNE:  p.taken = (rs1_val != rs2_val);
                    F3_BLT:  p.taken = lt_s(rs1_val, rs2_val);
                    F3_BGE:  p.taken = !lt_s(rs1_val, rs2_val);
                    F3_BLTU: p.taken = (rs1_val < rs2_val);
                    F3_BGEU: p.taken = (rs1_val >= rs2_val);
                    default: p.ill   = 1'b1;
                endcase
            end
            CLS_LUI: begin
                p.res_nd = (imm << 12) & UPPER_MASK;
                p.wr     = 1'b1;
            end
            CLS_AUIPC: begin
                p.res_nd = ((imm << 12) & UPPER_MASK) + pc;
                p.wr     = 1'b1;
            end
            CLS_JAL: begin
                p.res_nd = pc + LINK_OFS;
                p.wr     = 1'b1;
                p.taken  = 1'b1;
                p.tgt    = pc + imm;
            end
            CLS_JALR: begin
                p.res_nd = pc + LINK_OFS;
                p.wr     = 1'b1;
                p.taken  = 1'b1;
                p.tgt    = ea & JALR_MASK;
            end
            default: p.ill = 1'b1;
        endcase

        if (p.ill) begin
            p.res_nd = '0;
            p.wr     = 1'b0;
            p.taken  = 1'b0;
            p.tgt    = '0;
            p.addr   = '0;
            p.is_mul = 1'b0;
            p.is_div = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= p;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

@@ hdl/rvx_div_step.sv @@
// one restoring-divide stage: one quotient bit per stage
module rvx_div_step import rvx_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  pipe_t in_pipe,
    output logic  out_valid,
    output pipe_t out_pipe
);

    logic          valid_reg;
    pipe_t         pipe_reg;
    pipe_t         p;
    logic [XLEN:0] trial;
    logic [XLEN:0] diff;

    always_comb begin
        p     = in_pipe;
        trial = {in_pipe.rem, in_pipe.quo[XLEN-1]};
        diff  = trial - {1'b0, in_pipe.dvs};
        if (!diff[XLEN]) begin
            p.rem = diff[XLEN-1:0];
            p.quo = {in_pipe.quo[XLEN-2:0], 1'b1};
        end else begin
            p.rem = trial[XLEN-1:0];
            p.quo = {in_pipe.quo[XLEN-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= p;
        end
    end

    assign out_valid = valid_reg;
    assign out_pipe  = pipe_reg;

endmodule

@@ hdl/rvx_back.sv @@
// last stage: sign fixup, multiply half select and output register
module rvx_back import rvx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  pipe_t            in_pipe,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;
    logic [XLEN-1:0]  res;
    logic [XLEN-1:0]  dres;

    always_comb begin
        if (in_pipe.div0) begin
            dres = in_pipe.is_rem ? in_pipe.res_nd : '1;
        end else if (in_pipe.is_rem) begin
            dres = in_pipe.neg_r ? -in_pipe.rem : in_pipe.rem;
        end else begin
            dres = in_pipe.neg_q ? -in_pipe.quo : in_pipe.quo;
        end
        if (in_pipe.is_mul) begin
            res = in_pipe.mul_hi ? in_pipe.prod[2*XLEN-1:XLEN] : in_pipe.prod[XLEN-1:0];
        end else if (in_pipe.is_div) begin
            res = dres;
        end else begin
            res = in_pipe.res_nd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {5'd0, in_pipe.ill, in_pipe.addr, in_pipe.tgt,
                         in_pipe.taken, in_pipe.wr, res};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/rv32im_execute_unit.sv @@
// top level of the rv32im execute unit
//
// usage:
//   s_ channel carries one decoded instruction per transfer, m_ channel one result
//   per instruction, in the same order
//   pipeline: 34 register stages (one front stage, 32 divide stages, one output
//   stage); m_tvalid rises once the transfer has passed the front, divide and
//   output registers in turn; every instruction takes the same path so order holds
//   throughput: one instruction per cycle while the output is not stalled, set by
//   the fully pipelined divider with one quotient bit per stage
//   the pipeline moves as a whole: when the output register holds a result that
//   the receiver does not take, every stage holds and s_tready drops
//   reset clears all valid bits; no result is shown until new transfers arrive
//   division by zero, signed overflow divide and illegal codes follow risc-v rules
module rv32im_execute_unit import rvx_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // req_type[3:0] func3[6:4] func7[13:7] rs1_val[45:14] rs2_val[77:46]
    // imm[109:78] pc[141:110] load_word[173:142], zero pad above
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // result[31:0] writes_result[32] branch_taken[33] target[65:34]
    // mem_address[97:66] illegal[98], zero pad above
    output logic [OUT_W-1:0] m_tdata
);

    logic  adv;
    logic  front_valid;
    pipe_t front_pipe;
    logic  stg_valid [DIV_STAGES+1];
    pipe_t stg_pipe  [DIV_STAGES+1];

    // whole pipeline advances unless a finished result is waiting
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    rvx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .req_type  (s_tdata[3:0]),
        .func3     (s_tdata[6:4]),
        .func7     (s_tdata[13:7]),
        .rs1_val   (s_tdata[45:14]),
        .rs2_val   (s_tdata[77:46]),
        .imm       (s_tdata[109:78]),
        .pc        (s_tdata[141:110]),
        .load_word (s_tdata[173:142]),
        .out_valid (front_valid),
        .out_pipe  (front_pipe)
    );

    assign stg_valid[0] = front_valid;
    assign stg_pipe[0]  = front_pipe;

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        rvx_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (stg_valid[i]),
            .in_pipe   (stg_pipe[i]),
            .out_valid (stg_valid[i+1]),
            .out_pipe  (stg_pipe[i+1])
        );
    end

    rvx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (stg_valid[DIV_STAGES]),
        .in_pipe   (stg_pipe[DIV_STAGES]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

@@ hdl/rvx_checker.sv @@
// port-level checks for the rv32im execute unit, bound to the top level
module rvx_checker import rvx_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // no new transfer while the output is blocked
    a_backpress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

    // illegal results carry nothing else
    a_illegal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[98] |-> m_tdata[97:0] == '0)
        else $error("illegal result with nonzero fields");

    // no write-back means a zero result
    a_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("result value without write flag");

endmodule

bind rv32im_execute_unit rvx_checker u_rvx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/rv32im_execute_unit_tb.sv @@
// self-checking testbench for the rv32im execute unit: random and directed instructions
`timescale 1ns / 100ps
module rv32im_execute_unit_tb;
    import rvx_pkg::*;

    // last field sits in the lowest bits, matching the s_tdata layout
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] pc;
        logic [31:0] imm;
        logic [31:0] b;
        logic [31:0] a;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [3:0]  kind;
    } instr_t;

    // last field sits in the lowest bits, matching the m_tdata layout
    typedef struct packed {
        logic        ill;
        logic [31:0] addr;
        logic [31:0] tgt;
        logic        taken;
        logic        wr;
        logic [31:0] res;
    } outcome_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // req_type, func3, func7, rs1_val, rs2_val, imm, pc, load_word from bit 0 up
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // result, writes_result, branch_taken, target, mem_address, illegal from bit 0 up
    logic [OUT_W-1:0] m_tdata;

    instr_t   pending_instrs[$];
    outcome_t expected_outcomes[$];
    int       error_count = 0;
    int       sent_count = 0;
    int       total_count = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_off = 0;
    bit       hold_done = 0;
    bit       in_taken = 0;

    rv32im_execute_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic slt_s(logic [31:0] a, logic [31:0] b);
        return (a ^ 32'h80000000) < (b ^ 32'h80000000);
    endfunction

    function automatic logic [31:0] int_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                           logic [31:0] b);
        logic [63:0] ext;
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return {31'd0, slt_s(a, b)};
            F3_SLTU: return {31'd0, a < b};
            F3_XOR:  return a ^ b;
            F3_SR: begin
                ext = {{32{alt & a[31]}}, a};
                ext = ext >> b[4:0];
                return ext[31:0];
            end
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic [63:0] sa, sb, p;
        logic [31:0] ma, mb, q, r;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        case (f3)
            F3_MUL: begin p = {32'd0, a} * {32'd0, b}; return p[31:0]; end
            F3_MULH: begin p = sa * sb; return p[63:32]; end
            F3_MULHSU: begin p = sa * {32'd0, b}; return p[63:32]; end
            F3_MULHU: begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
            F3_DIVU: return b == 0 ? 32'hFFFFFFFF : a / b;
            F3_REMU: return b == 0 ? a : a % b;
            default: begin
                if (b == 0) return f3 == F3_DIV ? 32'hFFFFFFFF : a;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = ma % mb;
                if (f3 == F3_DIV) return (a[31] != b[31]) ? -q : q;
                return a[31] ? -r : r;
            end
        endcase
    endfunction

    function automatic outcome_t execute(instr_t i);
        outcome_t o;
        logic [31:0] v, w;
        o = '0;
        case (i.kind)
            CLS_REG: begin
                o.res = i.f7[0] ? muldiv(i.f3, i.a, i.b) : int_op(i.f3, i.f7 != 0, i.a, i.b);
                o.wr = 1;
            end
            CLS_IMM: begin
                o.res = int_op(i.f3, i.f3 == F3_SR && i.f7 != 0, i.a, i.imm);
                o.wr = 1;
            end
            CLS_LOAD: begin
                v = i.a + i.imm;
                o.addr = v & WORD_MASK;
                o.wr = 1;
                w = i.word >> (v[1:0] * 8);
                case (i.f3)
                    F3_LB:  o.res = {{24{w[7]}}, w[7:0]};
                    F3_LH:  o.res = {{16{w[15]}}, w[15:0]};
                    F3_LW:  o.res = i.word;
                    F3_LBU: o.res = {24'd0, w[7:0]};
                    F3_LHU: o.res = {16'd0, w[15:0]};
                    default: o.ill = 1;
                endcase
            end
            CLS_STORE: if (i.f3 <= 2) o.addr = i.a + i.imm; else o.ill = 1;
            CLS_BR: begin
                o.tgt = i.pc + i.imm;
                case (i.f3)
                    F3_BEQ:  o.taken = i.a == i.b;
                    F3_BNE:  o.taken = i.a != i.b;
                    F3_BLT:  o.taken = slt_s(i.a, i.b);
                    F3_BGE:  o.taken = !slt_s(i.a, i.b);
                    F3_BLTU: o.taken = i.a < i.b;
                    F3_BGEU: o.taken = i.a >= i.b;
                    default: o.ill = 1;
                endcase
            end
            CLS_LUI: begin o.res = {i.imm[19:0], 12'd0}; o.wr = 1; end
            CLS_AUIPC: begin o.res = {i.imm[19:0], 12'd0} + i.pc; o.wr = 1; end
            CLS_JAL: begin
                o.res = i.pc + 4; o.wr = 1; o.taken = 1; o.tgt = i.pc + i.imm;
            end
            CLS_JALR: begin
                o.res = i.pc + 4; o.wr = 1; o.taken = 1; o.tgt = (i.a + i.imm) & JALR_MASK;
            end
            default: o.ill = 1;
        endcase
        if (o.ill) o = '{res: 0, wr: 0, taken: 0, tgt: 0, addr: 0, ill: 1};
        return o;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return 32'h80000000;
            3: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_instr(logic [3:0] k, logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
                             logic [31:0] b, logic [31:0] imm);
        instr_t item;
        item = '{kind: k, f3: f3, f7: f7, a: a, b: b, imm: imm,
                 pc: $urandom, word: $urandom};
        pending_instrs.insert(pending_instrs.size(), item);
        total_count++;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // input handshake seen at the rising edge
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // driver: new transfer offered at the falling edge after a random gap
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                sent_count++;
                send_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (!s_tvalid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_instrs.size() > 0) begin
                    s_tdata <= IN_W'(pending_instrs[0]);
                    expected_outcomes.insert(expected_outcomes.size(),
                                             execute(pending_instrs.pop_front()));
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off partway through so the pipeline fills
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && sent_count >= 300) begin
                hold_done = 1;
                hold_off = 150;
            end else if (hold_off > 0) begin
                hold_off--;
            end
        end
    end

    // receiver ready with random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_off > 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0) recv_gap = $urandom_range(0, 9);
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[98:0];
            if (expected_outcomes.size() == 0) begin
                report("unexpected result", got.res, 0);
            end else begin
                want = expected_outcomes.pop_front();
                if (got.res !== want.res) report("result", got.res, want.res);
                if (got.wr !== want.wr) report("writes_result", got.wr, want.wr);
                if (got.taken !== want.taken) report("branch_taken", got.taken, want.taken);
                if (got.tgt !== want.tgt) report("target", got.tgt, want.tgt);
                if (got.addr !== want.addr) report("mem_address", got.addr, want.addr);
                if (got.ill !== want.ill) report("illegal", got.ill, want.ill);
            end
        end
    end

    initial begin
        logic [3:0] k;
        logic [6:0] f7;
        // directed: every class, divide corner cases, halfword at offset 3, illegal codes
        for (int f = 0; f < 8; f++) begin
            add_instr(CLS_REG, 3'(f), 7'd1, 32'h80000000, 32'hFFFFFFFF, 0);
        end
        add_instr(CLS_REG, F3_DIV, 7'd1, 32'd7, 32'd0, 0);
        add_instr(CLS_REG, F3_REM, 7'd1, 32'hFFFFFFF9, 32'd0, 0);
        add_instr(CLS_REG, F3_SR, 7'h20, 32'h80000000, 32'hFFFFFFE3, 0);
        add_instr(CLS_IMM, F3_SLL, 7'd0, 32'h1, 0, 32'hFFFFFFFF);
        add_instr(CLS_IMM, F3_SR, 7'h7F, 32'hF0000000, 0, 32'd36);
        add_instr(CLS_LOAD, F3_LH, 0, 32'd3, 0, 0);
        add_instr(CLS_LOAD, F3_LB, 0, 32'hFFFFFFFF, 0, 32'h7FFFFFFF);
        add_instr(CLS_LOAD, 3'd6, 0, 0, 0, 0);
        add_instr(CLS_STORE, 3'd5, 0, 1, 0, 1);
        add_instr(CLS_BR, 3'd2, 0, 1, 1, 8);
        add_instr(CLS_BR, F3_BLT, 0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        add_instr(CLS_LUI, 0, 0, 0, 0, 32'hFFFFFFFF);
        add_instr(CLS_AUIPC, 0, 0, 0, 0, 32'h80000);
        add_instr(CLS_JAL, 0, 0, 0, 0, 32'hFFFFFFFC);
        add_instr(CLS_JALR, 0, 0, 32'h3, 0, 0);
        add_instr(4'd15, 0, 0, 0, 0, 0);
        while (total_count < 850) begin
            k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            f7 = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 1) * 32) : 7'($urandom);
            f7 = f7 | 7'($urandom_range(0, 1));
            add_instr(k, 3'($urandom), f7, rand_val(), rand_val(), rand_val());
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_instrs.size() == 0 && sent_count == total_count);
        wait (expected_outcomes.size() == 0);
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
